// ----- rtl/core/vcsa_pkg.sv -----
package vcsa_pkg;

    // Parameter defaults
    localparam int MAX_TARGETS_DEF = 1024;
    localparam int COORD_BITS_DEF  = 24;

    // Configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 24;

    localparam logic [CFG_IW-1:0] REG_OBS_X  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_OBS_Y  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_OBS_Z  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_FACE_X = 3'd3;
    localparam logic [CFG_IW-1:0] REG_FACE_Y = 3'd4;
    localparam logic [CFG_IW-1:0] REG_FACE_Z = 3'd5;
    localparam logic [CFG_IW-1:0] REG_CONE   = 3'd6;
    localparam logic [CFG_IW-1:0] REG_RANGE  = 3'd7;

    // Field widths
    localparam int FACE_W  = 24;
    localparam int CONE_W  = 16;
    localparam int RANGE_W = 23;
    localparam int STR_W   = 16;
    localparam int IDX_W   = 10;
    localparam int OUT_TDW = 32;

    // Offset magnitude before the range test (coordinates up to 32 bits)
    localparam int MAG_W = 33;

    // Shift-add multiplier operands and product
    localparam int OP_W   = 24;
    localparam int PROD_W = 2 * OP_W;

    // Serial divider and square root
    localparam int DIVN_W = 64;
    localparam int DIVD_W = 48;
    localparam int QUO_W  = 17;
    localparam int SQ_W   = 48;
    localparam int ROOT_W = SQ_W / 2;

    localparam logic [QUO_W-1:0] ONE_Q15 = 17'd32768;
    localparam logic [QUO_W-1:0] ONE_Q16 = 17'd65536;

endpackage

// ----- rtl/core/vcsa_div.sv -----
module vcsa_div #(
    parameter int NW = vcsa_pkg::DIVN_W,
    parameter int DW = vcsa_pkg::DIVD_W,
    parameter int QW = vcsa_pkg::QUO_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_quo;
    logic          r_ovf;
    logic [DW:0]   w_trial;
    logic          w_ge;

    // One quotient bit per cycle, numerator enters MSB first
    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= '0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem <= w_ge ? DW'(w_trial - {1'b0, r_den}) : DW'(w_trial);
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], w_ge};
            r_ovf <= r_ovf | r_quo[QW-1];
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;

endmodule

// ----- rtl/core/vcsa_sqrt.sv -----
module vcsa_sqrt #(
    parameter int XW = vcsa_pkg::SQ_W
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [XW-1:0]   i_x,
    output logic            o_busy,
    output logic [XW/2-1:0] o_root
);

    localparam int RW = XW / 2;
    localparam int CW = $clog2(RW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [XW-1:0] r_x;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [RW+1:0] w_t;
    logic [RW+1:0] w_trial;
    logic          w_ge;

    // Digit-by-digit root: two radicand bits in, one root bit out per cycle
    assign w_t     = {r_rem[RW-1:0], r_x[XW-1:XW-2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge    = (w_t >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_t - w_trial) : w_t;
            r_root <= {r_root[RW-2:0], w_ge};
            r_x    <= {r_x[XW-3:0], 2'b00};
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == CW'(RW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ----- rtl/core/view_cone_strength_argmax_top.sv -----
// View-cone perception test with strongest-target tracking.
// Config channel (i_cfg_*): index 0..7 selects observer x/y/z, facing x/y/z,
// cone cosine and range; it is always ready. The user must write it only
// while idle; the block does not enforce this. Input stream (s_axis_*):
// one target position per transaction, tlast marks the last target of a
// batch. Output stream (m_axis_*): one result per target with visible,
// strength, best index and best found; tlast echoes the batch end and the
// best fields are final there.
// One target at a time. Units: a 24-bit shift-add product, a 48-bit square
// root, a 64-bit serial quotient. A target ends after the range check when
// an offset axis exceeds the range, after ten products when only the
// distance test fails, after twelve products, two roots and three quotients
// for a full cone test, and in between at the observer, with no facing or
// outside the cone. Results leave through an output register, so the next
// target is taken while a result waits; a stalled receiver holds the block
// only once a second result is ready.
// Reset clears configuration, the batch best state and both handshakes.
module view_cone_strength_argmax_top #(
    parameter int MAX_TARGETS = vcsa_pkg::MAX_TARGETS_DEF,
    parameter int COORD_BITS  = vcsa_pkg::COORD_BITS_DEF,
    localparam int IN_TDW     = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [vcsa_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [vcsa_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // target_x, target_y, target_z, zero pad
    input  logic [IN_TDW-1:0]           s_axis_tdata,
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // visible, strength[15:0], best_index[9:0], best_found, zero pad
    output logic [vcsa_pkg::OUT_TDW-1:0] m_axis_tdata,
    output logic                        m_axis_tlast
);

    localparam int CW     = COORD_BITS;
    localparam int SLOT_W = $clog2(MAX_TARGETS);
    localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
    localparam int MAG_W  = vcsa_pkg::MAG_W;
    localparam int OP_W   = vcsa_pkg::OP_W;
    localparam int PROD_W = vcsa_pkg::PROD_W;
    localparam int QUO_W  = vcsa_pkg::QUO_W;
    localparam int RNG_W  = vcsa_pkg::RANGE_W;
    localparam int STR_W  = vcsa_pkg::STR_W;
    localparam int MCNT_W = $clog2(OP_W);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_SQD  = 4'd2;
    localparam logic [3:0] S_SQF  = 4'd3;
    localparam logic [3:0] S_MULD = 4'd4;
    localparam logic [3:0] S_DIVC = 4'd5;
    localparam logic [3:0] S_DIVA = 4'd6;
    localparam logic [3:0] S_DIVR = 4'd7;
    localparam logic [3:0] S_MULS = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // Configuration registers
    logic [vcsa_pkg::CFG_DW-1:0] r_obs [3];
    logic [vcsa_pkg::FACE_W-1:0] r_fac [3];
    logic [vcsa_pkg::CONE_W-1:0] r_cone;
    logic [RNG_W-1:0]            r_range;

    // Sequencer and datapath
    logic [3:0]              r_state;
    logic                    r_run;
    logic [3:0]              r_k;
    logic                    r_last;
    logic [OP_W-1:0]         r_tmag [3];
    logic                    r_tneg [3];
    logic [PROD_W-1:0]       r_d2;
    logic [PROD_W-1:0]       r_f2;
    logic signed [PROD_W:0]  r_dot;
    logic [OP_W-1:0]         r_d;
    logic [PROD_W-1:0]       r_den;
    logic [QUO_W-1:0]        r_cdiff;
    logic [QUO_W-1:0]        r_cden;
    logic [QUO_W-1:0]        r_angle;
    logic [QUO_W-1:0]        r_dist;
    logic                    r_vis;
    logic [STR_W-1:0]        r_str;

    // Batch best state
    logic [STR_W-1:0]  r_best_lvl;
    logic [SLOT_W-1:0] r_best_slot;
    logic              r_any;
    logic [CNT_W-1:0]  r_cnt;

    // Output register
    logic                         r_ovalid;
    logic [vcsa_pkg::OUT_TDW-1:0] r_odata;
    logic                         r_olast;

    // Multiplier
    logic              r_mbusy;
    logic [MCNT_W-1:0] r_mcnt;
    logic [OP_W-1:0]   r_ma;
    logic [OP_W-1:0]   r_mb;
    logic [PROD_W-1:0] r_mp;
    logic [OP_W:0]     w_msum;
    logic [OP_W-1:0]   w_ma;
    logic [OP_W-1:0]   w_mb;
    logic              w_psign;
    logic              w_mgo;

    logic signed [MAG_W-1:0] w_to   [3];
    logic [MAG_W-1:0]        w_tmag [3];
    logic [OP_W-1:0]         w_fmag [3];
    logic                    w_inr;

    logic                          w_sgo;
    logic                          w_sbusy;
    logic [vcsa_pkg::ROOT_W-1:0]   w_root;
    logic                          w_dgo;
    logic                          w_dbusy;
    logic [vcsa_pkg::DIVN_W-1:0]   w_num;
    logic [vcsa_pkg::DIVD_W-1:0]   w_dden;
    logic [QUO_W-1:0]              w_quo;
    logic                          w_ovf;

    logic [PROD_W-1:0]       w_dotmag;
    logic [QUO_W-1:0]        w_qcos;
    logic signed [QUO_W:0]   w_cosv;
    logic signed [QUO_W:0]   w_cc;
    logic [PROD_W-1:0]       w_sprod;
    logic                    w_ofree;
    logic                    w_done;

    logic [STR_W-1:0]  n_best_lvl;
    logic [SLOT_W-1:0] n_best_slot;
    logic              n_any;
    logic [CNT_W-1:0]  n_cnt;

    // Config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs   <= '{default: '0};
            r_fac   <= '{default: '0};
            r_cone  <= '0;
            r_range <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vcsa_pkg::REG_OBS_X:  r_obs[0] <= i_cfg_data;
                vcsa_pkg::REG_OBS_Y:  r_obs[1] <= i_cfg_data;
                vcsa_pkg::REG_OBS_Z:  r_obs[2] <= i_cfg_data;
                vcsa_pkg::REG_FACE_X: r_fac[0] <= i_cfg_data;
                vcsa_pkg::REG_FACE_Y: r_fac[1] <= i_cfg_data;
                vcsa_pkg::REG_FACE_Z: r_fac[2] <= i_cfg_data;
                vcsa_pkg::REG_CONE:   r_cone   <= i_cfg_data[vcsa_pkg::CONE_W-1:0];
                vcsa_pkg::REG_RANGE:  r_range  <= i_cfg_data[RNG_W-1:0];
                default: ;
            endcase
        end
    end

    // Offsets and per-axis range test on the incoming target
    always_comb begin
        w_inr = 1'b1;
        for (int i = 0; i < 3; i++) begin
            w_to[i] = MAG_W'(signed'(s_axis_tdata[i*CW +: CW]))
                    - MAG_W'(signed'(CW'(r_obs[i])));
            w_tmag[i] = w_to[i][MAG_W-1] ? MAG_W'(-w_to[i]) : MAG_W'(w_to[i]);
            if (w_tmag[i] > MAG_W'(r_range)) begin
                w_inr = 1'b0;
            end
            w_fmag[i] = r_fac[i][OP_W-1] ? (~r_fac[i] + 1'b1) : r_fac[i];
        end
    end

    // Multiplier operand select
    always_comb begin
        w_ma    = '0;
        w_mb    = '0;
        w_psign = 1'b0;
        case (r_state)
            S_MUL: begin
                case (r_k)
                    4'd0: begin w_ma = r_tmag[0]; w_mb = r_tmag[0]; end
                    4'd1: begin w_ma = r_tmag[1]; w_mb = r_tmag[1]; end
                    4'd2: begin w_ma = r_tmag[2]; w_mb = r_tmag[2]; end
                    4'd3: begin w_ma = w_fmag[0]; w_mb = w_fmag[0]; end
                    4'd4: begin w_ma = w_fmag[1]; w_mb = w_fmag[1]; end
                    4'd5: begin w_ma = w_fmag[2]; w_mb = w_fmag[2]; end
                    4'd6: begin
                        w_ma = w_fmag[0]; w_mb = r_tmag[0];
                        w_psign = r_fac[0][OP_W-1] ^ r_tneg[0];
                    end
                    4'd7: begin
                        w_ma = w_fmag[1]; w_mb = r_tmag[1];
                        w_psign = r_fac[1][OP_W-1] ^ r_tneg[1];
                    end
                    4'd8: begin
                        w_ma = w_fmag[2]; w_mb = r_tmag[2];
                        w_psign = r_fac[2][OP_W-1] ^ r_tneg[2];
                    end
                    default: begin w_ma = OP_W'(r_range); w_mb = OP_W'(r_range); end
                endcase
            end
            S_MULD: begin
                w_ma = OP_W'(w_root);
                w_mb = r_d;
            end
            S_MULS: begin
                w_ma = OP_W'(r_dist);
                w_mb = OP_W'(r_angle);
            end
            default: ;
        endcase
    end

    assign w_mgo = !r_run && (r_state == S_MUL || r_state == S_MULD || r_state == S_MULS);
    assign w_sgo = !r_run && (r_state == S_SQD || r_state == S_SQF);
    assign w_dgo = !r_run && (r_state == S_DIVC || r_state == S_DIVA || r_state == S_DIVR);

    // Shift-add multiplier, one multiplier bit per cycle
    assign w_msum = (OP_W+1)'(r_mp[PROD_W-1:OP_W]) + (r_mb[0] ? (OP_W+1)'(r_ma) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else if (w_mgo) begin
            r_ma    <= w_ma;
            r_mb    <= w_mb;
            r_mp    <= '0;
            r_mcnt  <= '0;
            r_mbusy <= 1'b1;
        end else if (r_mbusy) begin
            r_mp   <= {w_msum, r_mp[OP_W-1:1]};
            r_mb   <= r_mb >> 1;
            r_mcnt <= r_mcnt + 1'b1;
            if (r_mcnt == MCNT_W'(OP_W - 1)) begin
                r_mbusy <= 1'b0;
            end
        end
    end

    // Square root and divider units
    vcsa_sqrt #(
        .XW (vcsa_pkg::SQ_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sgo),
        .i_x     ((r_state == S_SQD) ? r_d2 : r_f2),
        .o_busy  (w_sbusy),
        .o_root  (w_root)
    );

    assign w_dotmag = r_dot[PROD_W] ? PROD_W'(-r_dot) : PROD_W'(r_dot);

    always_comb begin
        case (r_state)
            S_DIVC: begin
                w_num  = vcsa_pkg::DIVN_W'({w_dotmag, 15'd0});
                w_dden = r_den;
            end
            S_DIVA: begin
                w_num  = vcsa_pkg::DIVN_W'({r_cdiff, 16'd0});
                w_dden = vcsa_pkg::DIVD_W'(r_cden);
            end
            default: begin
                w_num  = vcsa_pkg::DIVN_W'({RNG_W'(r_range - r_d[RNG_W-1:0]), 16'd0});
                w_dden = vcsa_pkg::DIVD_W'(r_range);
            end
        endcase
    end

    vcsa_div #(
        .NW (vcsa_pkg::DIVN_W),
        .DW (vcsa_pkg::DIVD_W),
        .QW (QUO_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dgo),
        .i_num   (w_num),
        .i_den   (w_dden),
        .o_busy  (w_dbusy),
        .o_quo   (w_quo),
        .o_ovf   (w_ovf)
    );

    // Cosine from the first quotient, clamped to 1.0
    assign w_qcos  = (w_ovf || w_quo > vcsa_pkg::ONE_Q15) ? vcsa_pkg::ONE_Q15 : w_quo;
    assign w_cosv  = r_dot[PROD_W] ? -signed'({1'b0, w_qcos}) : signed'({1'b0, w_qcos});
    assign w_cc    = (QUO_W+1)'(signed'(r_cone));
    assign w_sprod = r_mp >> 16;

    // Unit finished in this state
    always_comb begin
        case (r_state)
            S_MUL, S_MULD, S_MULS: w_done = r_run && !r_mbusy;
            S_SQD, S_SQF:          w_done = r_run && !w_sbusy;
            S_DIVC, S_DIVA, S_DIVR: w_done = r_run && !w_dbusy;
            default:               w_done = 1'b0;
        endcase
    end

    // Batch best update for the finished target
    always_comb begin
        n_best_lvl  = r_best_lvl;
        n_best_slot = r_best_slot;
        n_any       = r_any;
        n_cnt       = r_cnt;
        if (r_cnt < CNT_W'(MAX_TARGETS)) begin
            if (r_str > r_best_lvl) begin
                n_best_lvl  = r_str;
                n_best_slot = SLOT_W'(r_cnt);
                n_any       = 1'b1;
            end
            n_cnt = r_cnt + 1'b1;
        end
    end

    assign w_ofree = !r_ovalid || m_axis_tready;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run       <= 1'b0;
            r_ovalid    <= 1'b0;
            r_best_lvl  <= '0;
            r_best_slot <= '0;
            r_any       <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // S_DONE reloads the output register itself
            if (r_ovalid && m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            if (w_mgo || w_sgo || w_dgo) begin
                r_run <= 1'b1;
            end else if (w_done) begin
                r_run <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        for (int i = 0; i < 3; i++) begin
                            r_tmag[i] <= OP_W'(w_tmag[i]);
                            r_tneg[i] <= w_to[i][MAG_W-1];
                        end
                        r_last  <= s_axis_tlast;
                        r_d2    <= '0;
                        r_f2    <= '0;
                        r_dot   <= '0;
                        r_k     <= '0;
                        r_vis   <= 1'b0;
                        r_str   <= '0;
                        r_state <= w_inr ? S_MUL : S_DONE;
                    end
                end
                S_MUL: begin
                    if (w_done) begin
                        if (r_k < 4'd3) begin
                            r_d2 <= r_d2 + r_mp;
                        end else if (r_k < 4'd6) begin
                            r_f2 <= r_f2 + r_mp;
                        end else if (r_k < 4'd9) begin
                            r_dot <= w_psign ? r_dot - signed'({1'b0, r_mp})
                                             : r_dot + signed'({1'b0, r_mp});
                        end
                        r_k <= r_k + 1'b1;
                        if (r_k == 4'd9) begin
                            r_state <= (r_d2 > r_mp) ? S_DONE : S_SQD;
                        end
                    end
                end
                S_SQD: begin
                    if (w_done) begin
                        r_d <= OP_W'(w_root);
                        if (w_root == '0) begin
                            r_vis   <= 1'b1;
                            r_str   <= (r_range != '0) ? '1 : '0;
                            r_state <= S_DONE;
                        end else if (r_f2 == '0) begin
                            r_vis   <= 1'b1;
                            r_angle <= vcsa_pkg::ONE_Q16;
                            r_state <= S_DIVR;
                        end else begin
                            r_state <= S_SQF;
                        end
                    end
                end
                S_SQF: begin
                    if (w_done) begin
                        r_state <= S_MULD;
                    end
                end
                S_MULD: begin
                    if (w_done) begin
                        r_den   <= r_mp;
                        r_state <= S_DIVC;
                    end
                end
                S_DIVC: begin
                    if (w_done) begin
                        if (w_cosv < w_cc) begin
                            r_state <= S_DONE;
                        end else begin
                            r_cdiff <= QUO_W'(w_cosv - w_cc);
                            r_cden  <= QUO_W'(signed'({1'b0, vcsa_pkg::ONE_Q15}) - w_cc);
                            r_state <= S_DIVA;
                        end
                    end
                end
                S_DIVA: begin
                    if (w_done) begin
                        r_angle <= (w_ovf || w_quo > vcsa_pkg::ONE_Q16)
                                   ? vcsa_pkg::ONE_Q16 : w_quo;
                        r_vis   <= 1'b1;
                        r_state <= S_DIVR;
                    end
                end
                S_DIVR: begin
                    if (w_done) begin
                        r_dist  <= (w_ovf || w_quo > vcsa_pkg::ONE_Q16)
                                   ? vcsa_pkg::ONE_Q16 : w_quo;
                        r_state <= S_MULS;
                    end
                end
                S_MULS: begin
                    if (w_done) begin
                        r_str   <= (w_sprod > PROD_W'(16'hFFFF)) ? '1 : STR_W'(w_sprod);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_ofree) begin
                        r_ovalid <= 1'b1;
                        r_olast  <= r_last;
                        r_odata  <= vcsa_pkg::OUT_TDW'({
                            n_any,
                            n_any ? vcsa_pkg::IDX_W'(n_best_slot) : vcsa_pkg::IDX_W'(0),
                            r_str,
                            r_vis});
                        if (r_last) begin
                            r_best_lvl  <= '0;
                            r_best_slot <= '0;
                            r_any       <= 1'b0;
                            r_cnt       <= '0;
                        end else begin
                            r_best_lvl  <= n_best_lvl;
                            r_best_slot <= n_best_slot;
                            r_any       <= n_any;
                            r_cnt       <= n_cnt;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

endmodule
